// ----- rtl/core/lesf_pkg.sv -----
// lesf_pkg: shared widths, register codes and transaction structs for the
// largest empty square finder. No dependencies.
package lesf_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int CHAR_W     = 8;
	localparam int SIZE_W     = 11;
	localparam int IDX_W      = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = 8'd46;
	localparam logic [SIZE_W-1:0] GRID_COLS_RST  = 11'd1;
	localparam logic [SIZE_W-1:0] MAX_COLS_W     = 11'(MAX_COLS);
	localparam logic [IDX_W-1:0]  ROW_CAP        = 10'd1023;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EMPTY_CHAR = 1'b0,
		CFG_GRID_COLS  = 1'b1
	} cfg_idx_t;

	// one cell transaction as it enters the scoring stage
	typedef struct packed {
		logic             is_empty;
		logic             last;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
	} cell_req_t;

	// best square so far / emitted result
	typedef struct packed {
		logic [SIZE_W-1:0] sq_size;
		logic [IDX_W-1:0]  sq_top;
		logic [IDX_W-1:0]  sq_left;
	} best_t;

endpackage

// ----- rtl/core/lesf_cell_core.sv -----
// lesf_cell_core: line store, neighbor sizes, per-cell scoring and best tracking.
// Depends on lesf_pkg.
module lesf_cell_core import lesf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      acc,       // cell transaction accepted this edge
	input  cell_req_t req,       // cell being accepted
	input  logic      hold,      // result register full and stalled
	output logic      busy,      // scoring stage cannot take a new cell
	output logic      res_fire,  // last cell scored, result valid
	output best_t     res
);

	logic [SIZE_W-1:0] line_mem [MAX_COLS];

	logic              s1_vld_q;
	cell_req_t         s1_q;
	logic [SIZE_W-1:0] rd_q;
	logic              fwd_q;
	logic [SIZE_W-1:0] fwd_data_q;
	logic [SIZE_W-1:0] left_q;
	logic [SIZE_W-1:0] diag_q;
	best_t             best_q;

	logic              fire;
	logic [SIZE_W-1:0] above;
	logic [SIZE_W-1:0] min_ld;
	logic [SIZE_W-1:0] min3;
	logic [SIZE_W-1:0] size;
	logic [SIZE_W:0]   row_p1;
	logic [SIZE_W:0]   col_p1;
	best_t             best_nxt;

	assign fire     = s1_vld_q & ~(s1_q.last & hold);
	assign busy     = s1_vld_q & ~fire;
	assign res_fire = fire & s1_q.last;

	// bypass a write to the same slot landing on the read edge
	assign above  = fwd_q ? fwd_data_q : rd_q;
	assign min_ld = (above < left_q) ? above : left_q;
	assign min3   = (min_ld < diag_q) ? min_ld : diag_q;

	always_comb begin
		size = '0;
		if (s1_q.is_empty) begin
			if (s1_q.row == '0 || s1_q.col == '0) begin
				size = SIZE_W'(1);
			end else begin
				size = min3 + SIZE_W'(1);
			end
		end
	end

	assign row_p1 = {2'b00, s1_q.row} + (SIZE_W+1)'(1);
	assign col_p1 = {2'b00, s1_q.col} + (SIZE_W+1)'(1);

	always_comb begin
		best_nxt = best_q;
		if (size > best_q.sq_size) begin
			best_nxt.sq_size = size;
			best_nxt.sq_top  = (row_p1 >= {1'b0, size}) ?
				IDX_W'(row_p1 - {1'b0, size}) : '0;
			best_nxt.sq_left = (col_p1 >= {1'b0, size}) ?
				IDX_W'(col_p1 - {1'b0, size}) : '0;
		end
	end

	assign res = best_nxt;

	// line store: read on accept, write back when the cell is scored
	always_ff @(posedge clk) begin
		if (fire) begin
			line_mem[s1_q.col] <= size;
		end
		if (acc) begin
			rd_q       <= line_mem[req.col];
			fwd_q      <= fire && (s1_q.col == req.col);
			fwd_data_q <= size;
			s1_q       <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			left_q   <= '0;
			diag_q   <= '0;
			best_q   <= '0;
		end else begin
			if (acc) begin
				s1_vld_q <= 1'b1;
			end else if (fire) begin
				s1_vld_q <= 1'b0;
			end
			if (fire) begin
				if (s1_q.last) begin
					left_q <= '0;
					diag_q <= '0;
					best_q <= '0;
				end else begin
					best_q <= best_nxt;
					// row end is flagged by the front end as col wrapping to zero
					if (acc && req.col == '0) begin
						left_q <= '0;
						diag_q <= '0;
					end else begin
						left_q <= size;
						diag_q <= above;
					end
				end
			end
		end
	end

	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !s1_q.last) |=> (best_q.sq_size >= $past(best_q.sq_size)))
		else $error("best size shrank within a grid");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> (best_q == '0 && left_q == '0 && diag_q == '0))
		else $error("state not cleared after last cell");

	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (s1_vld_q && $stable(s1_q) && $stable(rd_q)))
		else $error("stalled cell lost or changed");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !acc)
		else $error("cell accepted while scoring stage blocked");

endmodule

// ----- rtl/core/largest_empty_square_finder_top.sv -----
// largest_empty_square_finder_top: front end counters, configuration registers
// and result register around lesf_cell_core. Depends on lesf_pkg, lesf_cell_core.
//
// Channel   Dir  Handshake             Payload
// -------   ---  --------------------  ---------------------------------------
// in        in   in_valid / in_stall   cell_char[7:0], last_cell
// out       out  out_valid / out_stall square_size[10:0], square_top[9:0],
//                                      square_left[9:0]
// cfg       in   cfg_we                cfg_idx[0], cfg_data[10:0]
//
// One cell per cycle while the input is not stalled. A cell is read from the line
// store on the edge it is accepted and scored/written back on the edge it leaves
// the scoring stage; a last cell then passes through the result register.
// Reset clears counters, neighbor sizes, best and the valid flags; the line
// store is not cleared, every entry is written in row 0 before its value is used.
// Input stalls only when a last cell is waiting and the result register is
// full and stalled; otherwise cells keep flowing while a result waits.
module largest_empty_square_finder_top import lesf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CHAR_W-1:0]     cell_char,
	input  logic                  last_cell,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SIZE_W-1:0]     square_size,
	output logic [IDX_W-1:0]      square_top,
	output logic [IDX_W-1:0]      square_left,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CHAR_W-1:0] empty_char_q;
	logic [SIZE_W-1:0] grid_cols_q;
	logic [IDX_W-1:0]  col_q;
	logic [IDX_W-1:0]  row_q;
	logic              out_vld_q;
	best_t             out_q;

	logic              acc;
	logic              busy;
	logic              res_fire;
	best_t             res;
	logic [SIZE_W-1:0] eff_cols;
	logic              row_end;
	cell_req_t         req;

	assign in_stall = busy;
	assign acc      = in_valid & ~busy;

	// column count clamped to 1..MAX_COLS
	always_comb begin
		eff_cols = grid_cols_q;
		if (grid_cols_q == '0) begin
			eff_cols = SIZE_W'(1);
		end else if (grid_cols_q > MAX_COLS_W) begin
			eff_cols = MAX_COLS_W;
		end
	end

	assign row_end = ({1'b0, col_q} + SIZE_W'(1)) >= eff_cols;

	// col in req doubles as the row-end mark for the core: the next cell
	// arriving at column zero means neighbor sizes restart
	always_comb begin
		req.is_empty = (cell_char == empty_char_q);
		req.last     = last_cell;
		req.col      = col_q;
		req.row      = row_q;
	end

	lesf_cell_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.req      (req),
		.hold     (out_vld_q & out_stall),
		.busy     (busy),
		.res_fire (res_fire),
		.res      (res)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_char_q <= EMPTY_CHAR_RST;
			grid_cols_q  <= GRID_COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_EMPTY_CHAR: empty_char_q <= cfg_data[CHAR_W-1:0];
				CFG_GRID_COLS:  grid_cols_q  <= cfg_data[SIZE_W-1:0];
			endcase
		end
	end

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_cell) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				if (row_q < ROW_CAP) begin
					row_q <= row_q + IDX_W'(1);
				end
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_fire) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_vld_q;
	assign square_size = out_q.sq_size;
	assign square_top  = out_q.sq_top;
	assign square_left = out_q.sq_left;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_stall) |-> !res_fire)
		else $error("result overwritten while stalled");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ({1'b0, col_q} < eff_cols || $past(cfg_we)))
		else $error("column counter past row width");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_cell) |=> (col_q == '0 && row_q == '0))
		else $error("counters not restarted after last cell");

endmodule
